// File: src/rmm_pkg.sv
// Shared types and constants for the running median multiset block.
package rmm_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths on the channels
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEDIAN_W = 17;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned FAULT_W  = 2;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_ABSENT = 2'd1,
    FAULT_FULL   = 2'd2
  } fault_e;

  // Compare flags from the shared unit
  typedef struct packed {
    logic gt;  // stored entry above the request sample
    logic eq;  // stored entry equals the request sample
  } cmp_flags_t;

endpackage

// File: src/rmm_if.sv
// Request and result channel interfaces.
interface rmm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [rmm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface rmm_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmm_pkg::MEDIAN_W-1:0] median_x2;
  logic [rmm_pkg::COUNT_W-1:0]         element_count;
  logic [rmm_pkg::FAULT_W-1:0]         fault;

  modport source (output valid, output median_x2, output element_count, output fault,
                  input ready);
  modport sink   (input valid, input median_x2, input element_count, input fault,
                  output ready);
endinterface

// File: src/rmm_store.sv
// Ordered sample store: single write port, one registered read port.
module rmm_store #(
  parameter int unsigned DEPTH = rmm_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = rmm_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);

  logic signed [WIDTH-1:0] mem_q [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rmm_alu.sv
// Shared compare and add unit used by the compare and median steps of the sequencer.
module rmm_alu #(
  parameter int unsigned WIDTH = rmm_pkg::SAMPLE_BITS_DEF
) (
  input  logic signed [WIDTH-1:0] entry_i,
  input  logic signed [WIDTH-1:0] sample_i,
  input  logic signed [WIDTH-1:0] acc_i,
  input  logic                    use_acc_i,
  output rmm_pkg::cmp_flags_t     flags_o,
  output logic signed [WIDTH:0]   sum_o
);
  import rmm_pkg::*;

  logic signed [WIDTH:0] op_a;
  logic signed [WIDTH:0] op_b;

  always_comb begin
    flags_o.gt = entry_i > sample_i;
    flags_o.eq = entry_i == sample_i;
    // odd count doubles the middle entry, even count adds the lower middle
    op_a  = (WIDTH+1)'(entry_i);
    op_b  = use_acc_i ? (WIDTH+1)'(acc_i) : (WIDTH+1)'(entry_i);
    sum_o = op_a + op_b;
  end

endmodule

// File: src/running_median_multiset_unit.sv
// Flow: an insert walks down past larger entries, a remove searches up from the bottom and
// then shifts the later entries down; a full insert or an absent remove reports its fault.
// One request at a time: no new request is taken until the result word is issued, and
// the store walk goes one entry at a time through the single read port.
// Reset: count and last median clear at once; store contents are left as they are and
// the block leaves reset idle and ready for a request.
module running_median_multiset_unit #(
  parameter int unsigned CAPACITY    = rmm_pkg::CAPACITY_DEF,
  parameter int unsigned SAMPLE_BITS = rmm_pkg::SAMPLE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rmm_req_if.sink   req_i,
  rmm_res_if.source res_o
);
  import rmm_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_INS_RD  = 11'b000_0000_0010,
    ST_INS_CMP = 11'b000_0000_0100,
    ST_REM_RD  = 11'b000_0000_1000,
    ST_REM_CMP = 11'b000_0001_0000,
    ST_SH_RD   = 11'b000_0010_0000,
    ST_SH_WR   = 11'b000_0100_0000,
    ST_MED_RD  = 11'b000_1000_0000,
    ST_MED_A   = 11'b001_0000_0000,
    ST_MED_B   = 11'b010_0000_0000,
    ST_FIN     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]                 pos_q, pos_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic signed [SAMPLE_BITS-1:0] v_q, v_d;
  logic signed [SAMPLE_BITS-1:0] acc_q, acc_d;
  logic signed [MEDIAN_W-1:0]    median_q, median_d;
  fault_e                        fault_q, fault_d;

  logic                          res_valid_q, res_valid_d;
  logic signed [MEDIAN_W-1:0]    res_median_q, res_median_d;
  logic [COUNT_W-1:0]            res_count_q, res_count_d;
  fault_e                        res_fault_q, res_fault_d;

  // memory and shared unit hookup
  logic                          we;
  logic [CW-1:0]                 waddr_w;
  logic signed [SAMPLE_BITS-1:0] wdata;
  logic                          re;
  logic [CW-1:0]                 raddr_w;
  logic signed [SAMPLE_BITS-1:0] rdata;
  cmp_flags_t                    flags;
  logic signed [SAMPLE_BITS:0]   sum;
  logic                          use_acc;

  logic [31:0]                   raw_w;
  logic signed [SAMPLE_BITS-1:0] sample_v;
  logic signed [32:0]            sum_w;
  logic [31:0]                   cnt_w;
  logic [CW-1:0]                 pos_m1;
  logic [CW-1:0]                 pos_p1;
  logic [CW-1:0]                 half;
  logic                          out_free;

  assign raw_w    = {{(32-SAMPLE_W){1'b0}}, req_i.sample};
  assign sample_v = signed'(raw_w[SAMPLE_BITS-1:0]);
  assign sum_w    = 33'(sum);
  assign cnt_w    = {{(32-CW){1'b0}}, cnt_q};
  assign pos_m1   = pos_q - 1'b1;
  assign pos_p1   = pos_q + 1'b1;
  assign half     = cnt_q >> 1;
  assign out_free = !res_valid_q || res_o.ready;

  rmm_store #(
    .DEPTH (CAPACITY),
    .WIDTH (SAMPLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_w[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr_w[AW-1:0]),
    .rdata_o (rdata)
  );

  rmm_alu #(
    .WIDTH (SAMPLE_BITS)
  ) u_alu (
    .entry_i   (rdata),
    .sample_i  (v_q),
    .acc_i     (acc_q),
    .use_acc_i (use_acc),
    .flags_o   (flags),
    .sum_o     (sum)
  );

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    v_d          = v_q;
    acc_d        = acc_q;
    median_d     = median_q;
    fault_d      = fault_q;
    res_valid_d  = res_valid_q;
    res_median_d = res_median_q;
    res_count_d  = res_count_q;
    res_fault_d  = res_fault_q;
    we           = 1'b0;
    waddr_w      = pos_q;
    wdata        = v_q;
    re           = 1'b0;
    raddr_w      = pos_q;
    use_acc      = 1'b0;

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          v_d     = sample_v;
          fault_d = FAULT_NONE;
          if (req_type_e'(req_i.req_type) == REQ_REMOVE) begin
            pos_d   = '0;
            state_d = ST_REM_RD;
          end else begin
            pos_d   = cnt_q;
            state_d = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (cnt_q == CAP_CNT) begin
          fault_d = FAULT_FULL;
          state_d = ST_FIN;
        end else if (pos_q == '0) begin
          we      = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_MED_RD;
        end else begin
          re      = 1'b1;
          raddr_w = pos_m1;
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (flags.gt) begin
          // open a gap: larger entry moves up one place
          wdata   = rdata;
          pos_d   = pos_m1;
          state_d = ST_INS_RD;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_MED_RD;
        end
      end
      ST_REM_RD: begin
        if (pos_q == cnt_q) begin
          fault_d = FAULT_ABSENT;
          state_d = ST_FIN;
        end else begin
          re      = 1'b1;
          state_d = ST_REM_CMP;
        end
      end
      ST_REM_CMP: begin
        if (flags.eq) begin
          state_d = ST_SH_RD;
        end else begin
          pos_d   = pos_p1;
          state_d = ST_REM_RD;
        end
      end
      ST_SH_RD: begin
        if (pos_p1 >= cnt_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ST_MED_RD;
        end else begin
          re      = 1'b1;
          raddr_w = pos_p1;
          state_d = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        we      = 1'b1;
        wdata   = rdata;
        pos_d   = pos_p1;
        state_d = ST_SH_RD;
      end
      ST_MED_RD: begin
        if (cnt_q == '0) begin
          // empty set keeps the last median
          state_d = ST_FIN;
        end else begin
          re      = 1'b1;
          raddr_w = cnt_q[0] ? half : half - 1'b1;
          state_d = ST_MED_A;
        end
      end
      ST_MED_A: begin
        if (cnt_q[0]) begin
          median_d = sum_w[MEDIAN_W-1:0];
          state_d  = ST_FIN;
        end else begin
          acc_d   = rdata;
          re      = 1'b1;
          raddr_w = half;
          state_d = ST_MED_B;
        end
      end
      ST_MED_B: begin
        use_acc  = 1'b1;
        median_d = sum_w[MEDIAN_W-1:0];
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          res_valid_d  = 1'b1;
          res_median_d = median_q;
          res_count_d  = cnt_w[COUNT_W-1:0];
          res_fault_d  = fault_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      median_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      median_q    <= median_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    v_q          <= v_d;
    acc_q        <= acc_d;
    fault_q      <= fault_d;
    res_median_q <= res_median_d;
    res_count_q  <= res_count_d;
    res_fault_q  <= res_fault_d;
  end

  assign req_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid         = res_valid_q;
  assign res_o.median_x2     = res_median_q;
  assign res_o.element_count = res_count_q;
  assign res_o.fault         = res_fault_q;

endmodule

// File: src/rmm_checker.sv
// Port-level checks for the running median block, bound to the top level.
module rmm_checker #(
  parameter int unsigned CAPACITY = rmm_pkg::CAPACITY_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid_i,
  input logic                                req_ready_i,
  input logic                                res_valid_i,
  input logic                                res_ready_i,
  input logic signed [rmm_pkg::MEDIAN_W-1:0] median_x2_i,
  input logic [rmm_pkg::COUNT_W-1:0]         element_count_i,
  input logic [rmm_pkg::FAULT_W-1:0]         fault_i
);
  import rmm_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_SHOWN = COUNT_W'(CAPACITY);

  // a waiting result word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(median_x2_i)
      && $stable(element_count_i) && $stable(fault_i))
    else $error("result word changed while stalled");

  // an accepted request keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous still in flight");

  // a full fault only ever reports a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && fault_i == FAULT_FULL |-> element_count_i == CAP_SHOWN)
    else $error("full fault with store not full");

  // odd count: the doubled middle entry is even
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && element_count_i[0] |-> !median_x2_i[0])
    else $error("odd count with odd doubled median");

endmodule

bind running_median_multiset_unit rmm_checker #(
  .CAPACITY (CAPACITY)
) u_rmm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .median_x2_i     (res_o.median_x2),
  .element_count_i (res_o.element_count),
  .fault_i         (res_o.fault)
);

// File: tb/rmm_median_checker.sv
// Watches both channels of the running median block, predicts each result word and compares.
`timescale 1ns / 1ps

module rmm_median_checker
  import rmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rmm_req_if          req_mon,
  rmm_res_if          res_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned absent_seen,
  output int unsigned full_seen
);

  typedef struct {
    logic signed [MEDIAN_W-1:0] median_x2;
    logic [COUNT_W-1:0]         element_count;
    fault_e                     fault;
  } median_word_t;

  // Own copy of the block's state: ascending store, fill level, last doubled median
  logic signed [SAMPLE_W-1:0] sorted_vals [CAPACITY_DEF];
  int unsigned                held = 0;
  logic signed [MEDIAN_W-1:0] median_now = '0;
  median_word_t               expected_words [$];

  function automatic logic signed [MEDIAN_W-1:0] widen(logic signed [SAMPLE_W-1:0] v);
    return {v[SAMPLE_W-1], v};
  endfunction

  function automatic median_word_t predict_median(req_type_e kind,
                                                  logic signed [SAMPLE_W-1:0] value);
    median_word_t w;
    int unsigned  pos;
    fault_e       f;
    f = FAULT_NONE;
    if (kind == REQ_INSERT) begin
      if (held >= CAPACITY_DEF) begin
        f = FAULT_FULL;
      end else begin
        // insert after any equal entries, shifting larger ones up
        pos = held;
        while (pos > 0 && sorted_vals[pos-1] > value) begin
          sorted_vals[pos] = sorted_vals[pos-1];
          pos--;
        end
        sorted_vals[pos] = value;
        held++;
      end
    end else begin
      pos = 0;
      while (pos < held && sorted_vals[pos] != value) pos++;
      if (pos >= held) begin
        f = FAULT_ABSENT;
      end else begin
        for (int unsigned i = pos; i + 1 < held; i++) sorted_vals[i] = sorted_vals[i+1];
        held--;
      end
    end
    // empty set keeps the previous median
    if (f == FAULT_NONE && held != 0) begin
      if (held % 2 == 1)
        median_now = {sorted_vals[held/2], 1'b0};
      else
        median_now = widen(sorted_vals[held/2 - 1]) + widen(sorted_vals[held/2]);
    end
    w.median_x2     = median_now;
    w.element_count = COUNT_W'(held);
    w.fault         = f;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    median_word_t want;
    if (!rst_ni) begin
      held       = 0;
      median_now = '0;
      expected_words.delete();
      pending <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_words = {expected_words,
                          predict_median(req_type_e'(req_mon.req_type), req_mon.sample)};
      if (res_mon.valid && res_mon.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: median_x2 %0d count %0d fault %0d",
                 res_mon.median_x2, res_mon.element_count, res_mon.fault);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          checked <= checked + 1;
          if (want.fault == FAULT_ABSENT) absent_seen <= absent_seen + 1;
          if (want.fault == FAULT_FULL) full_seen <= full_seen + 1;
          if (res_mon.median_x2 !== want.median_x2 ||
              res_mon.element_count !== want.element_count ||
              res_mon.fault !== want.fault) begin
            fail_count <= fail_count + 1;
            if (res_mon.median_x2 !== want.median_x2)
              $error("median_x2: expected %0d, got %0d", want.median_x2, res_mon.median_x2);
            if (res_mon.element_count !== want.element_count)
              $error("element_count: expected %0d, got %0d", want.element_count,
                     res_mon.element_count);
            if (res_mon.fault !== want.fault)
              $error("fault: expected %0d, got %0d", want.fault, res_mon.fault);
          end
        end
      end
      pending <= expected_words.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the running median block; checking sits in rmm_median_checker.
`timescale 1ns / 1ps

module tb_top;
  import rmm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned DRAIN_WAIT   = 2 * CAPACITY_DEF + 8;
  localparam int unsigned CYCLE_LIMIT  = 1_200_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   stalls_on = 1'b0;

  int unsigned fail_count, pending, checked, absent_seen, full_seen;
  int unsigned sent = 0;
  int unsigned cycles = 0;

  // values the block should hold, used only to pick removes that hit
  logic signed [SAMPLE_W-1:0] held_pool [$];

  rmm_req_if req_ch ();
  rmm_res_if res_ch ();

  running_median_multiset_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  rmm_median_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_mon     (req_ch),
    .res_mon     (res_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .absent_seen (absent_seen),
    .full_seen   (full_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure in bursts
  initial begin
    int unsigned hold_off;
    hold_off = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        hold_off--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        hold_off = $urandom_range(1, 9) - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_request(req_type_e kind, logic signed [SAMPLE_W-1:0] value);
    int idx;
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.sample   <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    if (kind == REQ_INSERT) begin
      if (held_pool.size() < CAPACITY_DEF) held_pool = {held_pool, value};
    end else begin
      idx = -1;
      foreach (held_pool[i]) if (idx < 0 && held_pool[i] == value) idx = i;
      if (idx >= 0) held_pool.delete(idx);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int          v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = int'($urandom);
    end else if (sel < 70) begin
      v = int'($urandom_range(0, 16)) - 8;          // narrow band, many duplicates
    end else if (sel < 85) begin
      case ($urandom_range(0, 5))
        0: v = -32768;
        1: v = -32767;
        2: v = -1;
        3: v = 0;
        4: v = 32766;
        default: v = 32767;
      endcase
    end else begin
      v = ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 7))
                                      : -32768 + int'($urandom_range(0, 7));
    end
    return v[SAMPLE_W-1:0];
  endfunction

  initial begin
    int unsigned phase_len, mode, ins_pct;
    req_type_e   kind;
    logic signed [SAMPLE_W-1:0] value;

    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_INSERT;
    req_ch.sample   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes, duplicates, absent removes, median kept on empty
    stalls_on = 1'b1;
    push_request(REQ_REMOVE, 16'sd0);
    push_request(REQ_INSERT, 16'sd32767);
    push_request(REQ_INSERT, -16'sd32768);
    push_request(REQ_INSERT, 16'sd0);
    push_request(REQ_INSERT, 16'sd0);
    push_request(REQ_REMOVE, 16'sd0);
    push_request(REQ_REMOVE, 16'sd0);
    push_request(REQ_REMOVE, 16'sd1234);
    push_request(REQ_REMOVE, 16'sd32767);
    push_request(REQ_REMOVE, -16'sd32768);
    push_request(REQ_REMOVE, -16'sd32768);
    push_request(REQ_INSERT, -16'sd32768);
    push_request(REQ_INSERT, -16'sd32768);
    push_request(REQ_REMOVE, -16'sd32768);
    push_request(REQ_REMOVE, -16'sd32768);
    push_request(REQ_INSERT, 16'sd32767);
    push_request(REQ_INSERT, 16'sd32767);
    push_request(REQ_INSERT, -16'sd1);
    push_request(REQ_INSERT, 16'sd1);
    push_request(REQ_REMOVE, -16'sd1);
    push_request(REQ_REMOVE, 16'sd32767);
    push_request(REQ_REMOVE, 16'sd1);
    push_request(REQ_REMOVE, 16'sd32767);

    // random phases: filling (can reach the full store), draining, balanced
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      mode      = $urandom_range(0, 2);
      ins_pct   = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        if (sent >= RANDOM_ITEMS) break;
        if (sent + QUIET_TAIL >= RANDOM_ITEMS) stalls_on = 1'b0;
        if ($urandom_range(0, 99) < ins_pct) begin
          kind  = REQ_INSERT;
          value = pick_sample();
        end else begin
          kind = REQ_REMOVE;
          if (held_pool.size() != 0 && $urandom_range(0, 9) != 0)
            value = held_pool[$urandom_range(0, held_pool.size() - 1)];
          else
            value = pick_sample();
        end
        push_request(kind, value);
      end
    end

    stalls_on = 1'b0;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d requests, %0d result words compared", sent, checked);
    $display("faults seen: %0d removes of absent values, %0d inserts into a full store",
             absent_seen, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
